### src/triangle_quality_classifier_defines.svh
// ----------------------------------------------------------------------------
// Triangle quality classifier assertion macros
// Shared concurrent assertion forms, clocked on aclk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_QUALITY_CLASSIFIER_DEFINES_SVH
`define TRIANGLE_QUALITY_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define TQC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TQC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality classifier package
// Widths, codes and the types that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package tqc_pkg;

    localparam int COORD_FRAC_BITS = 6;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = COORD_W + 1;      // vertex difference, signed
    localparam int SUM_W     = COORD_W + 2;      // three-coordinate sum, signed
    localparam int THR_BASE  = 24;
    localparam int THR_W     = 5 + 3 + COORD_FRAC_BITS;
    localparam int CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W + 1;
    localparam int SQ_W      = 2 * COORD_W;      // squared difference
    localparam int EDGE_W    = SQ_W + 2;         // squared edge length
    localparam int PROD_W    = 2 * DIFF_W;       // signed difference product
    localparam int CROSS_W   = PROD_W + 1;       // cross component, signed
    localparam int MAG_W     = PROD_W;           // cross component magnitude
    localparam int HALF_W    = MAG_W / 2;        // split for squaring
    localparam int PART_W    = 2 * HALF_W;
    localparam int SQR_W     = 2 * MAG_W;        // full square
    localparam int ESQ_SPLIT = SQR_W / 2;
    localparam int AREA_W    = SQR_W + 2;        // sum of three squares
    localparam int RATIO_W   = 16;
    localparam int SCALED_W  = ESQ_SPLIT + RATIO_W;
    localparam int RHS_W     = SQR_W + RATIO_W;
    localparam int LHS_W     = AREA_W + RATIO_W;
    localparam int MEASURE_W = 64;
    localparam int AREA_SHIFT = 8;

    localparam int LOD_W   = 2;
    localparam int MASK_W  = 8;
    localparam int BLOCK_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THIN_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOD_LEVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIRTY_MASK = 2'd2;

    localparam logic [MASK_W-1:0] DIRTY_MASK_RESET = 8'hFF;

    typedef enum logic [1:0] {
        VERDICT_SKIP       = 2'd0,
        VERDICT_DEGENERATE = 2'd1,
        VERDICT_THIN       = 2'd2,
        VERDICT_KEEP       = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [RATIO_W-1:0] thin_ratio;
        logic [LOD_W-1:0]   lod_level;
        logic [MASK_W-1:0]  dirty_mask;
    } cfg_t;

    // v[vertex][axis], raw two's complement coordinates
    typedef struct packed {
        logic [2:0][2:0][COORD_W-1:0] v;
    } tri_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]        block;
        logic                      skip;
        logic                      emax_zero;
        logic [EDGE_W-1:0]         emax;
        logic [2:0][MAG_W-1:0]     crm;
    } geo_t;

    typedef struct packed {
        logic [BLOCK_W-1:0]  block;
        logic                skip;
        logic                emax_zero;
        logic [AREA_W-1:0]   area;
        logic [SCALED_W-1:0] pr_lo;
        logic [SCALED_W-1:0] pr_hi;
    } sq_t;

endpackage

### src/tqc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality classifier configuration registers
// Write-only register file: thinness ratio, level of detail, dirty mask.
// ----------------------------------------------------------------------------
module tqc_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tqc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tqc_pkg::CFG_DATA_W-1:0]     cfg_data,
    output tqc_pkg::cfg_t                      cfg
);

    tqc_pkg::cfg_t cfg_reg;
    tqc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                tqc_pkg::CFG_IDX_THIN_RATIO: begin
                    cfg_next.thin_ratio = cfg_data[tqc_pkg::RATIO_W-1:0];
                end
                tqc_pkg::CFG_IDX_LOD_LEVEL: begin
                    cfg_next.lod_level = cfg_data[tqc_pkg::LOD_W-1:0];
                end
                tqc_pkg::CFG_IDX_DIRTY_MASK: begin
                    cfg_next.dirty_mask = cfg_data[tqc_pkg::MASK_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.thin_ratio <= '0;
            cfg_reg.lod_level  <= '0;
            cfg_reg.dirty_mask <= tqc_pkg::DIRTY_MASK_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### src/tqc_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality classifier geometry section
// Four stages: differences and sums, products and octant test, edge sums and
// cross components, largest edge and cross magnitudes.
// ----------------------------------------------------------------------------
`include "triangle_quality_classifier_defines.svh"

module tqc_geom (
    input  logic          aclk,
    input  logic          aresetn,
    input  tqc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  tqc_pkg::tri_t in_tri,
    output logic          out_valid,
    input  logic          out_ready,
    output tqc_pkg::geo_t out_geo
);

    logic [3:0] valid_reg;
    logic [3:0] stage_ready;

    // stage 1
    logic signed [tqc_pkg::SUM_W-1:0]  s1_sum_reg  [3];
    logic signed [tqc_pkg::SUM_W-1:0]  s1_sum_next [3];
    logic signed [tqc_pkg::DIFF_W-1:0] s1_ab_reg   [3];
    logic signed [tqc_pkg::DIFF_W-1:0] s1_ab_next  [3];
    logic signed [tqc_pkg::DIFF_W-1:0] s1_bc_reg   [3];
    logic signed [tqc_pkg::DIFF_W-1:0] s1_bc_next  [3];
    logic signed [tqc_pkg::DIFF_W-1:0] s1_ac_reg   [3];
    logic signed [tqc_pkg::DIFF_W-1:0] s1_ac_next  [3];

    // stage 2
    logic [tqc_pkg::BLOCK_W-1:0]       s2_block_reg;
    logic [tqc_pkg::BLOCK_W-1:0]       s2_block_next;
    logic                              s2_skip_reg;
    logic                              s2_skip_next;
    logic [tqc_pkg::SQ_W-1:0]          s2_sq_reg   [9];
    logic [tqc_pkg::SQ_W-1:0]          s2_sq_next  [9];
    logic signed [tqc_pkg::PROD_W-1:0] s2_prod_reg [6];
    logic signed [tqc_pkg::PROD_W-1:0] s2_prod_next[6];
    logic signed [tqc_pkg::PROD_W-1:0] sq_full     [9];
    logic [tqc_pkg::THR_W-1:0]         thr;
    logic signed [tqc_pkg::CMP_W-1:0]  thr_cmp;

    // stage 3
    logic [tqc_pkg::BLOCK_W-1:0]        s3_block_reg;
    logic                               s3_skip_reg;
    logic [tqc_pkg::EDGE_W-1:0]         s3_edge_reg  [3];
    logic [tqc_pkg::EDGE_W-1:0]         s3_edge_next [3];
    logic signed [tqc_pkg::CROSS_W-1:0] s3_cross_reg [3];
    logic signed [tqc_pkg::CROSS_W-1:0] s3_cross_next[3];

    // stage 4
    tqc_pkg::geo_t                      geo_reg;
    tqc_pkg::geo_t                      geo_next;
    logic [tqc_pkg::EDGE_W-1:0]         emax01;
    logic [tqc_pkg::EDGE_W-1:0]         emax;
    logic [tqc_pkg::CROSS_W-1:0]        cross_neg [3];

    // a stage takes a new item when it is empty or its content moves on
    always_comb begin
        stage_ready[3] = !valid_reg[3] || out_ready;
        for (int k = 2; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[3];
    assign out_geo   = geo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < 4; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 1: coordinate sums and edge vectors
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s1_sum_next[i] = tqc_pkg::SUM_W'($signed(in_tri.v[0][i]))
                           + tqc_pkg::SUM_W'($signed(in_tri.v[1][i]))
                           + tqc_pkg::SUM_W'($signed(in_tri.v[2][i]));
            s1_ab_next[i] = tqc_pkg::DIFF_W'($signed(in_tri.v[1][i]))
                          - tqc_pkg::DIFF_W'($signed(in_tri.v[0][i]));
            s1_bc_next[i] = tqc_pkg::DIFF_W'($signed(in_tri.v[2][i]))
                          - tqc_pkg::DIFF_W'($signed(in_tri.v[1][i]));
            s1_ac_next[i] = tqc_pkg::DIFF_W'($signed(in_tri.v[2][i]))
                          - tqc_pkg::DIFF_W'($signed(in_tri.v[0][i]));
        end
    end

    // stage 2: octant test, squared differences, cross-product terms
    always_comb begin
        thr = tqc_pkg::THR_W'(tqc_pkg::THR_BASE)
              << (tqc_pkg::THR_W'(cfg.lod_level) + tqc_pkg::THR_W'(tqc_pkg::COORD_FRAC_BITS));
        thr_cmp = $signed(tqc_pkg::CMP_W'(thr));
        for (int i = 0; i < 3; i++) begin
            s2_block_next[i] = (tqc_pkg::CMP_W'(s1_sum_reg[i]) >= thr_cmp);
        end
        s2_skip_next = !cfg.dirty_mask[s2_block_next];

        for (int i = 0; i < 3; i++) begin
            sq_full[i]     = s1_ab_reg[i] * s1_ab_reg[i];
            sq_full[3 + i] = s1_bc_reg[i] * s1_bc_reg[i];
            sq_full[6 + i] = s1_ac_reg[i] * s1_ac_reg[i];
        end
        for (int k = 0; k < 9; k++) begin
            s2_sq_next[k] = tqc_pkg::SQ_W'(sq_full[k]);
        end

        s2_prod_next[0] = s1_ab_reg[1] * s1_ac_reg[2];
        s2_prod_next[1] = s1_ab_reg[2] * s1_ac_reg[1];
        s2_prod_next[2] = s1_ab_reg[2] * s1_ac_reg[0];
        s2_prod_next[3] = s1_ab_reg[0] * s1_ac_reg[2];
        s2_prod_next[4] = s1_ab_reg[0] * s1_ac_reg[1];
        s2_prod_next[5] = s1_ab_reg[1] * s1_ac_reg[0];
    end

    // stage 3: edge lengths and cross components
    always_comb begin
        for (int e = 0; e < 3; e++) begin
            s3_edge_next[e] = tqc_pkg::EDGE_W'(s2_sq_reg[3*e])
                            + tqc_pkg::EDGE_W'(s2_sq_reg[3*e + 1])
                            + tqc_pkg::EDGE_W'(s2_sq_reg[3*e + 2]);
            s3_cross_next[e] = tqc_pkg::CROSS_W'(s2_prod_reg[2*e])
                             - tqc_pkg::CROSS_W'(s2_prod_reg[2*e + 1]);
        end
    end

    // stage 4: largest edge and cross magnitudes
    always_comb begin
        emax01 = (s3_edge_reg[1] > s3_edge_reg[0]) ? s3_edge_reg[1] : s3_edge_reg[0];
        emax   = (s3_edge_reg[2] > emax01) ? s3_edge_reg[2] : emax01;
        geo_next.block     = s3_block_reg;
        geo_next.skip      = s3_skip_reg;
        geo_next.emax      = emax;
        geo_next.emax_zero = (emax == '0);
        for (int i = 0; i < 3; i++) begin
            cross_neg[i] = -s3_cross_reg[i];
            geo_next.crm[i] = s3_cross_reg[i][tqc_pkg::CROSS_W-1]
                            ? cross_neg[i][tqc_pkg::MAG_W-1:0]
                            : s3_cross_reg[i][tqc_pkg::MAG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            s1_sum_reg <= s1_sum_next;
            s1_ab_reg  <= s1_ab_next;
            s1_bc_reg  <= s1_bc_next;
            s1_ac_reg  <= s1_ac_next;
        end
        if (stage_ready[1]) begin
            s2_block_reg <= s2_block_next;
            s2_skip_reg  <= s2_skip_next;
            s2_sq_reg    <= s2_sq_next;
            s2_prod_reg  <= s2_prod_next;
        end
        if (stage_ready[2]) begin
            s3_block_reg <= s2_block_reg;
            s3_skip_reg  <= s2_skip_reg;
            s3_edge_reg  <= s3_edge_next;
            s3_cross_reg <= s3_cross_next;
        end
        if (stage_ready[3]) begin
            geo_reg <= geo_next;
        end
    end

    `TQC_ASSERT_NEXT(a_geo_stall_hold, out_valid && !out_ready, out_valid && $stable(out_geo), "geometry section changed a stalled item")
    `TQC_ASSERT_NOW(a_geo_emax_zero, out_valid, out_geo.emax_zero == (out_geo.emax == '0), "largest-edge zero flag out of step")

endmodule

### src/tqc_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality classifier squaring section
// Three stages: split partial products, square assembly, area sum and scaling
// of the squared largest edge by the thinness ratio.
// ----------------------------------------------------------------------------
module tqc_square (
    input  logic          aclk,
    input  logic          aresetn,
    input  tqc_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  tqc_pkg::geo_t in_geo,
    output logic          out_valid,
    input  logic          out_ready,
    output tqc_pkg::sq_t  out_sq
);

    logic [2:0] valid_reg;
    logic [2:0] stage_ready;

    // four operands: three cross magnitudes, then the largest edge
    logic [tqc_pkg::MAG_W-1:0]  opnd     [4];
    logic [tqc_pkg::HALF_W-1:0] half_hi  [4];
    logic [tqc_pkg::HALF_W-1:0] half_lo  [4];

    logic [tqc_pkg::PART_W-1:0] s5_hh_reg [4];
    logic [tqc_pkg::PART_W-1:0] s5_hh_next[4];
    logic [tqc_pkg::PART_W-1:0] s5_hl_reg [4];
    logic [tqc_pkg::PART_W-1:0] s5_hl_next[4];
    logic [tqc_pkg::PART_W-1:0] s5_ll_reg [4];
    logic [tqc_pkg::PART_W-1:0] s5_ll_next[4];
    logic [tqc_pkg::BLOCK_W-1:0] s5_block_reg;
    logic                        s5_skip_reg;
    logic                        s5_ez_reg;

    logic [tqc_pkg::SQR_W-1:0]   s6_sqr_reg [4];
    logic [tqc_pkg::SQR_W-1:0]   s6_sqr_next[4];
    logic [tqc_pkg::BLOCK_W-1:0] s6_block_reg;
    logic                        s6_skip_reg;
    logic                        s6_ez_reg;

    tqc_pkg::sq_t sq_reg;
    tqc_pkg::sq_t sq_next;

    always_comb begin
        stage_ready[2] = !valid_reg[2] || out_ready;
        for (int k = 1; k >= 0; k--) begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[2];
    assign out_sq    = sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_ready[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < 3; k++) begin
                if (stage_ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // stage 5: x^2 = hh*2^(2H) + 2*hl*2^H + ll with H = HALF_W
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            opnd[j] = in_geo.crm[j];
        end
        opnd[3] = in_geo.emax;
        for (int j = 0; j < 4; j++) begin
            half_hi[j]    = opnd[j][tqc_pkg::MAG_W-1:tqc_pkg::HALF_W];
            half_lo[j]    = opnd[j][tqc_pkg::HALF_W-1:0];
            s5_hh_next[j] = half_hi[j] * half_hi[j];
            s5_hl_next[j] = half_hi[j] * half_lo[j];
            s5_ll_next[j] = half_lo[j] * half_lo[j];
        end
    end

    // stage 6: assemble the squares
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            s6_sqr_next[j] = (tqc_pkg::SQR_W'(s5_hh_reg[j]) << (2 * tqc_pkg::HALF_W))
                           + (tqc_pkg::SQR_W'(s5_hl_reg[j]) << (tqc_pkg::HALF_W + 1))
                           + tqc_pkg::SQR_W'(s5_ll_reg[j]);
        end
    end

    // stage 7: area sum; squared edge times ratio in two halves
    always_comb begin
        sq_next.block     = s6_block_reg;
        sq_next.skip      = s6_skip_reg;
        sq_next.emax_zero = s6_ez_reg;
        sq_next.area      = tqc_pkg::AREA_W'(s6_sqr_reg[0])
                          + tqc_pkg::AREA_W'(s6_sqr_reg[1])
                          + tqc_pkg::AREA_W'(s6_sqr_reg[2]);
        sq_next.pr_lo     = s6_sqr_reg[3][tqc_pkg::ESQ_SPLIT-1:0] * cfg.thin_ratio;
        sq_next.pr_hi     = s6_sqr_reg[3][tqc_pkg::SQR_W-1:tqc_pkg::ESQ_SPLIT]
                          * cfg.thin_ratio;
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[0]) begin
            s5_hh_reg    <= s5_hh_next;
            s5_hl_reg    <= s5_hl_next;
            s5_ll_reg    <= s5_ll_next;
            s5_block_reg <= in_geo.block;
            s5_skip_reg  <= in_geo.skip;
            s5_ez_reg    <= in_geo.emax_zero;
        end
        if (stage_ready[1]) begin
            s6_sqr_reg   <= s6_sqr_next;
            s6_block_reg <= s5_block_reg;
            s6_skip_reg  <= s5_skip_reg;
            s6_ez_reg    <= s5_ez_reg;
        end
        if (stage_ready[2]) begin
            sq_reg <= sq_next;
        end
    end

endmodule

### src/tqc_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality classifier decision stage
// Thinness compare, verdict and area measure into the output register.
// ----------------------------------------------------------------------------
`include "triangle_quality_classifier_defines.svh"

module tqc_decide (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tqc_pkg::sq_t                     in_sq,
    output logic                             m_valid,
    input  logic                             m_ready,
    output tqc_pkg::verdict_t                m_verdict,
    output logic [tqc_pkg::BLOCK_W-1:0]      m_block_index,
    output logic [tqc_pkg::MEASURE_W-1:0]    m_area_measure
);

    logic                            m_valid_reg;
    tqc_pkg::verdict_t               m_verdict_reg;
    tqc_pkg::verdict_t               m_verdict_next;
    logic [tqc_pkg::BLOCK_W-1:0]     m_block_index_reg;
    logic [tqc_pkg::MEASURE_W-1:0]   m_area_measure_reg;
    logic [tqc_pkg::MEASURE_W-1:0]   m_area_measure_next;

    logic [tqc_pkg::RHS_W-1:0]       rhs;
    logic [tqc_pkg::LHS_W-1:0]       lhs;
    logic                            thin;
    logic                            degenerate;

    assign in_ready       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_verdict      = m_verdict_reg;
    assign m_block_index  = m_block_index_reg;
    assign m_area_measure = m_area_measure_reg;

    always_comb begin
        rhs = (tqc_pkg::RHS_W'(in_sq.pr_hi) << tqc_pkg::ESQ_SPLIT)
            + tqc_pkg::RHS_W'(in_sq.pr_lo);
        lhs = tqc_pkg::LHS_W'(in_sq.area) << tqc_pkg::RATIO_W;
        thin = (lhs <= tqc_pkg::LHS_W'(rhs));
        degenerate = in_sq.emax_zero || (in_sq.area == '0);

        if (in_sq.skip) begin
            m_verdict_next = tqc_pkg::VERDICT_SKIP;
        end else if (degenerate) begin
            m_verdict_next = tqc_pkg::VERDICT_DEGENERATE;
        end else if (thin) begin
            m_verdict_next = tqc_pkg::VERDICT_THIN;
        end else begin
            m_verdict_next = tqc_pkg::VERDICT_KEEP;
        end

        // area stays below 2^AREA_W, so the shifted value never saturates
        if (in_sq.skip) begin
            m_area_measure_next = '0;
        end else begin
            m_area_measure_next = tqc_pkg::MEASURE_W'(in_sq.area >> tqc_pkg::AREA_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            m_verdict_reg      <= m_verdict_next;
            m_block_index_reg  <= in_sq.block;
            m_area_measure_reg <= m_area_measure_next;
        end
    end

    `TQC_ASSERT_NOW(a_skip_zero_area, m_valid_reg && (m_verdict_reg == tqc_pkg::VERDICT_SKIP), m_area_measure_reg == '0, "skipped triangle carries a nonzero area")
    `TQC_ASSERT_NOW(a_measure_range, m_valid_reg, m_area_measure_reg[tqc_pkg::MEASURE_W-1:tqc_pkg::AREA_W-tqc_pkg::AREA_SHIFT] == '0, "area measure above its reachable range")
    `TQC_ASSERT_NOW(a_degenerate_flag, in_valid && !in_sq.skip && in_sq.emax_zero, m_verdict_next == tqc_pkg::VERDICT_DEGENERATE, "zero-length triangle not marked degenerate")

endmodule

### src/triangle_quality_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle quality classifier
// Octant block test against a dirty mask, then degenerate / thin / kept
// classification from exact squared edge and cross-product magnitudes.
// ----------------------------------------------------------------------------
//  channel   prefix  handshake             payload
//  input     s_      s_valid / s_ready     s_a_x .. s_c_z, signed 16 bit
//  result    m_      m_valid / m_ready     m_verdict, m_block_index,
//                                          m_area_measure
//  config    cfg_    cfg_valid / cfg_ready cfg_index, cfg_data
//
//  One triangle per cycle unless m_ready stalls the output; each result
//  passes through 8 register stages (4 geometry, 3 squaring, 1 decision).
//  Ready runs back through the stage valid bits, so empty stages fill even
//  while a result waits on m_ready; cfg_ready is always high.
//  aresetn (synchronous) clears all stage valid bits and the registers
//  (ratio 0, level 0, mask all ones).
// ----------------------------------------------------------------------------
module triangle_quality_classifier (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_a_x,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_a_y,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_a_z,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_b_x,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_b_y,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_b_z,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_c_x,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_c_y,
    input  logic signed [tqc_pkg::COORD_W-1:0]   s_c_z,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_verdict,
    output logic [tqc_pkg::BLOCK_W-1:0]          m_block_index,
    output logic [tqc_pkg::MEASURE_W-1:0]        m_area_measure,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tqc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tqc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    tqc_pkg::cfg_t     cfg;
    tqc_pkg::tri_t     in_tri;
    tqc_pkg::geo_t     geo;
    tqc_pkg::sq_t      sq;
    tqc_pkg::verdict_t verdict;
    logic              geo_valid;
    logic              geo_ready;
    logic              sq_valid;
    logic              sq_ready;

    always_comb begin
        in_tri.v[0][0] = s_a_x;
        in_tri.v[0][1] = s_a_y;
        in_tri.v[0][2] = s_a_z;
        in_tri.v[1][0] = s_b_x;
        in_tri.v[1][1] = s_b_y;
        in_tri.v[1][2] = s_b_z;
        in_tri.v[2][0] = s_c_x;
        in_tri.v[2][1] = s_c_y;
        in_tri.v[2][2] = s_c_z;
    end

    assign m_verdict = verdict;

    tqc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tqc_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_tri    (in_tri),
        .out_valid (geo_valid),
        .out_ready (geo_ready),
        .out_geo   (geo)
    );

    tqc_square u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (geo_valid),
        .in_ready  (geo_ready),
        .in_geo    (geo),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_sq    (sq)
    );

    tqc_decide u_decide (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (sq_valid),
        .in_ready       (sq_ready),
        .in_sq          (sq),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_verdict      (verdict),
        .m_block_index  (m_block_index),
        .m_area_measure (m_area_measure)
    );

endmodule
